@@ hw/rtl/hsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hsd_pkg;
  localparam int NumBucketsDef  = 1024;
  localparam int BucketDepthDef = 8;
  localparam logic [19:0] HashPrime = 20'd999149;
  // 2^32 and 2^20 reduced by the hash prime, for folding the wide sum
  localparam logic [19:0] HashFold32 = 20'd624894;
  localparam logic [15:0] HashFold20 = 16'd49427;
  localparam logic [13:0] TotalMax  = 14'h3fff;
  localparam logic [3:0]  FillOutMax = 4'd15;

  localparam logic [1:0] RegHashMult   = 2'd0;
  localparam logic [1:0] RegHashAdd    = 2'd1;
  localparam logic [1:0] RegBucketCnt  = 2'd2;

  typedef enum logic [2:0] {
    HS_IDLE, HS_MUL, HS_ADD, HS_MODP, HS_MODB, HS_PUSH
  } hash_state_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_FILL, BK_SCAN, BK_CMP, BK_DONE
  } back_state_t;
endpackage
`default_nettype wire

@@ hw/rtl/hash_set_dedup_stats.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path from key to result with the back end free: product and offset, folding
// by the prime, bit-serial remainder by the bucket count, a push, a pop, then
// a bucket scan that reads the fill and compares each stored key in turn.
// The hash unit takes a new key only after pushing the last one; the table
// scan overlaps the next hash through a two-entry queue.
// Reset: synchronous; totals cleared, then every bucket fill cleared while input is held off.
module hash_set_dedup_stats import hsd_pkg::*; #(
  parameter int NUM_BUCKETS = NumBucketsDef,
  parameter int BUCKET_DEPTH = BucketDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // key
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // bucket[9:0] was_new overflow conflict_count[13:0] largest_fill[3:0] distinct_count[13:0]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  logic [31:0] hash_mult, hash_add;
  logic [10:0] bucket_count;
  logic push, q_full, q_empty, pop, clearing, front_ready;
  logic [31:0] push_key;
  logic [BW-1:0] push_bucket;
  logic [BW+31:0] q_rd;
  logic [BW-1:0] ob;
  logic onew, oovf;
  logic [13:0] oconf, odist;
  logic [3:0] omax;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mult <= 32'd1; hash_add <= '0; bucket_count <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegHashMult:  hash_mult <= cfg_wdata;
        RegHashAdd:   hash_add <= cfg_wdata;
        RegBucketCnt: bucket_count <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign s_tready = front_ready && !clearing;

  hsd_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk, .rst, .in_key(s_tdata), .in_valid(s_tvalid && !clearing),
    .in_ready(front_ready), .hash_mult, .hash_add, .bucket_count,
    .push, .push_key, .push_bucket, .q_full);

  hsd_queue #(.W(BW+32)) u_queue (
    .clk, .rst, .push, .wdata({push_bucket, push_key}), .full(q_full),
    .pop, .rdata(q_rd), .empty(q_empty));

  hsd_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
    .clk, .rst, .q_empty, .q_key(q_rd[31:0]), .q_bucket(q_rd[BW+31:32]),
    .pop, .out_valid(m_tvalid), .out_ready(m_tready), .out_bucket(ob),
    .out_new(onew), .out_ovf(oovf), .out_conf(oconf), .out_max(omax),
    .out_dist(odist), .clearing);

  assign m_tdata = {4'd0, odist, omax, oconf, oovf, onew, 10'(ob)};

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[10] && m_tdata[11])) else $error("new and overflow");
  a_noclr: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("accept while clearing");
  a_q: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("queue overrun");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while waiting");
endmodule
`default_nettype wire

@@ hw/rtl/hsd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Front end: takes a key, hashes it over several cycles, pushes (key, bucket)
module hsd_front import hsd_pkg::*; #(
  parameter int NUM_BUCKETS = NumBucketsDef,
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [31:0]     in_key,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [31:0]     hash_mult,
  input  wire logic [31:0]     hash_add,
  input  wire logic [10:0]     bucket_count,
  output logic                 push,
  output logic [31:0]          push_key,
  output logic [BW-1:0]        push_bucket,
  input  wire logic            q_full
);
  localparam int CW = BW + 1;
  localparam logic [CW-1:0] NbMax = CW'(NUM_BUCKETS);

  hash_state_t state, state_next;
  logic [31:0] key;
  logic [63:0] acc;
  logic [19:0] rem;
  logic [5:0]  cnt;
  logic [CW-1:0] nb;
  logic [51:0] fold_hi;
  logic [27:0] fold_lo;
  logic [19:0] prime_red;
  logic [20:0] mtrial;

  assign in_ready = (state == HS_IDLE);
  assign push = (state == HS_PUSH) && !q_full;
  assign push_key = key;
  assign push_bucket = BW'(rem);

  // effective bucket count: zero reads as one, clipped to the table size
  always_comb begin
    if ({1'b0, bucket_count} == 12'd0) nb = CW'(1);
    else if (32'(bucket_count) > 32'(NUM_BUCKETS)) nb = NbMax;
    else nb = CW'(bucket_count);
  end

  always_comb begin
    state_next = state;
    case (state)
      HS_IDLE: if (in_valid) state_next = HS_MUL;
      HS_MUL:  state_next = HS_ADD;
      HS_ADD:  state_next = HS_MODP;
      HS_MODP: if (acc[63:20] == 44'd0) state_next = HS_MODB;
      HS_MODB: if (cnt == 6'd0) state_next = HS_PUSH;
      HS_PUSH: if (!q_full) state_next = HS_IDLE;
      default: state_next = HS_IDLE;
    endcase
  end

  // prime remainder by folding: high part times 2^n mod prime, plus low part
  assign fold_hi = 52'(acc[63:32]) * 52'(HashFold32);
  assign fold_lo = 28'(acc[31:20]) * 28'(HashFold20);
  assign prime_red = (acc[19:0] >= HashPrime) ? acc[19:0] - HashPrime : acc[19:0];

  // restoring remainder by the bucket count, one bit a cycle
  assign mtrial = {((cnt == 6'd19) ? 20'd0 : rem), acc[19]};

  always_ff @(posedge clk) begin
    if (rst) state <= HS_IDLE;
    else state <= state_next;
    case (state)
      HS_IDLE: if (in_valid) key <= in_key;
      // 32x32 low product plus sign correction (k = key - 2^32*s)
      HS_MUL: acc <= 64'(hash_mult) * 64'(key)
                     - (key[31] ? {hash_mult, 32'd0} : 64'd0);
      HS_ADD: acc <= acc + 64'(hash_add);
      HS_MODP: begin
        if (acc[63:32] != 32'd0) acc <= 64'(fold_hi) + 64'(acc[31:0]);
        else if (acc[31:20] != 12'd0) acc <= 64'(fold_lo) + 64'(acc[19:0]);
        else begin
          acc <= {44'd0, prime_red};
          cnt <= 6'd19;
        end
      end
      HS_MODB: begin
        acc <= {acc[62:0], 1'b0};
        if (mtrial >= 21'(nb)) rem <= 20'(mtrial - 21'(nb));
        else rem <= mtrial[19:0];
        cnt <= cnt - 6'd1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/hsd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue between hashing and table work
module hsd_queue import hsd_pkg::*; #(
  parameter int W = 42
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  logic [W-1:0] mem [2];
  logic wp, rp;
  logic [1:0] count;
  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) mem[wp] <= wdata;
  end
endmodule
`default_nettype wire

@@ hw/rtl/hsd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Back end: clears fills, scans a bucket, appends, keeps totals, drives the result
module hsd_back import hsd_pkg::*; #(
  parameter int NUM_BUCKETS = NumBucketsDef,
  parameter int BUCKET_DEPTH = BucketDepthDef,
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
  localparam int DW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1,
  localparam int FW = $clog2(BUCKET_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire logic [31:0]   q_key,
  input  wire logic [BW-1:0] q_bucket,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [BW-1:0]      out_bucket,
  output logic               out_new,
  output logic               out_ovf,
  output logic [13:0]        out_conf,
  output logic [3:0]         out_max,
  output logic [13:0]        out_dist,
  output logic               clearing
);
  back_state_t state, state_next;
  logic [FW-1:0] fill_mem [NUM_BUCKETS];
  logic [31:0]   key_mem  [NUM_BUCKETS << DW];
  logic [FW-1:0] fill_rd;
  logic [31:0]   key_rd;
  logic [BW:0]   clr;
  logic [FW-1:0] idx;
  logic [31:0]   key;
  logic [BW-1:0] bkt;
  logic [FW-1:0] fill;
  logic [13:0]   conf, dist_cnt;
  logic [FW-1:0] maxf;
  logic [FW-1:0] fill_inc;
  logic          found;

  assign clearing = !clr[BW];
  assign pop = (state == BK_IDLE) && !q_empty && !clearing && !out_valid;
  assign fill_inc = fill + FW'(1);
  assign out_conf = conf;
  assign out_dist = dist_cnt;
  assign out_max = (32'(maxf) > 32'(FillOutMax)) ? FillOutMax : 4'(maxf);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (pop) state_next = BK_FILL;
      BK_FILL: state_next = BK_SCAN;
      BK_SCAN: state_next = (idx < fill) ? BK_CMP : BK_DONE;
      BK_CMP:  state_next = (key_rd == key) ? BK_DONE : BK_SCAN;
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (clearing) fill_mem[clr[BW-1:0]] <= '0;
    else if (state == BK_DONE && !found && 32'(fill) < 32'(BUCKET_DEPTH))
      fill_mem[bkt] <= fill_inc;
    fill_rd <= fill_mem[q_bucket];
    if (state == BK_DONE && !found && 32'(fill) < 32'(BUCKET_DEPTH))
      key_mem[{bkt, DW'(fill)}] <= key;
    key_rd <= key_mem[{bkt, DW'(idx)}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE; clr <= '0; out_valid <= 1'b0;
      conf <= '0; dist_cnt <= '0; maxf <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr <= clr + (BW+1)'(1);
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        BK_IDLE: if (pop) begin
          key <= q_key; bkt <= q_bucket; idx <= '0; found <= 1'b0;
        end
        BK_FILL: fill <= fill_rd;
        BK_SCAN: ;
        BK_CMP: if (key_rd == key) found <= 1'b1;
                else idx <= idx + FW'(1);
        BK_DONE: begin
          out_valid <= 1'b1;
          out_bucket <= bkt;
          out_new <= 1'b0;
          out_ovf <= 1'b0;
          if (!found) begin
            if (32'(fill) >= 32'(BUCKET_DEPTH)) out_ovf <= 1'b1;
            else begin
              out_new <= 1'b1;
              if (fill_inc > maxf) maxf <= fill_inc;
              if (dist_cnt != TotalMax) dist_cnt <= dist_cnt + 14'd1;
              if (fill != '0 && conf != TotalMax) conf <= conf + 14'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import hsd_pkg::*;

  localparam int NBUCK      = 1024;
  localparam int DEPTH      = 8;
  localparam int STALL_MAX  = 20000;
  localparam int SETTLE     = 120;

  // m_tdata layout, highest bit first
  typedef struct packed {
    logic [13:0] distinct;
    logic [3:0]  lfill;
    logic [13:0] confl;
    logic        ovf;
    logic        was_new;
    logic [9:0]  bucket;
  } dedup_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  hash_set_dedup_stats dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow copy of the set and its statistics
  logic [31:0] mdl_mult, mdl_add;
  logic [10:0] mdl_bcount;
  logic [31:0] mdl_keys [NBUCK][DEPTH];
  int unsigned mdl_fill [NBUCK];
  int unsigned mdl_confl, mdl_distinct, mdl_maxfill;

  dedup_res_t  pending_res[$];
  int          errors = 0;
  int          keys_sent = 0;
  int          results_seen = 0;
  int          overflows_seen = 0;
  int          dups_seen = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_cycles = 0;
  logic [31:0] key_pool[64];

  function automatic dedup_res_t insert_key(input logic [31:0] k);
    dedup_res_t r;
    logic [63:0] v;
    int unsigned nb, h;
    bit hit;
    nb = (mdl_bcount == 0) ? 1 : (mdl_bcount > NBUCK) ? NBUCK : mdl_bcount;
    v = {32'b0, mdl_mult} * {{32{k[31]}}, k} + {32'b0, mdl_add};
    v = v % 64'd999149;
    h = int'(v % nb);
    hit = 1'b0;
    for (int i = 0; i < mdl_fill[h]; i++)
      if (mdl_keys[h][i] == k) hit = 1'b1;
    r = '0;
    r.bucket = h[9:0];
    if (!hit) begin
      if (mdl_fill[h] >= DEPTH) begin
        r.ovf = 1'b1;
      end else begin
        mdl_keys[h][mdl_fill[h]] = k;
        mdl_fill[h]++;
        r.was_new = 1'b1;
        if (mdl_fill[h] > mdl_maxfill) mdl_maxfill = mdl_fill[h];
        if (mdl_distinct < 16383) mdl_distinct++;
        if (mdl_fill[h] != 1 && mdl_confl < 16383) mdl_confl++;
      end
    end
    r.confl    = mdl_confl[13:0];
    r.lfill    = (mdl_maxfill > 15) ? 4'd15 : mdl_maxfill[3:0];
    r.distinct = mdl_distinct[13:0];
    return r;
  endfunction

  // offer one key, leave valid high after acceptance
  task automatic send_key(input logic [31:0] k);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= k;
    do @(posedge clk); while (!s_tready);
    pending_res.push_back(insert_key(k));
    keys_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegHashMult:  mdl_mult   = val;
      RegHashAdd:   mdl_add    = val;
      RegBucketCnt: mdl_bcount = val[10:0];
      default: ;
    endcase
  endtask

  task automatic report(input string fld, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0d, got %0d", $realtime, fld, exp_v, act_v);
    end
  endtask

  // result side: checking, ready pattern, hold-off and watchdog
  initial begin
    dedup_res_t e, a;
    int idle_run;
    idle_run = 0;
    forever begin
      @(posedge clk);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_run = 0;
      else idle_run++;
      if (idle_run > STALL_MAX) begin
        $display("timeout: no item moved for %0d cycles", STALL_MAX);
        $display("RESULT: ERROR");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        a = m_tdata[43:0];
        results_seen++;
        if (pending_res.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $realtime, m_tdata);
        end else begin
          e = pending_res.pop_front();
          report("bucket", e.bucket, a.bucket);
          report("was_new", e.was_new, a.was_new);
          report("overflow", e.ovf, a.ovf);
          report("conflict_count", e.confl, a.confl);
          report("largest_fill", e.lfill, a.lfill);
          report("distinct_count", e.distinct, a.distinct);
          if (e.ovf) overflows_seen++;
          else if (!e.was_new) dups_seen++;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic test_corner_keys();
    send_key(32'h0000_0000);
    send_key(32'h0000_0001);
    send_key(32'hFFFF_FFFF);
    send_key(32'h7FFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h0000_0001);
    send_key(32'h8000_0000);
  endtask

  // one bucket only, so it fills and then drops new keys; then zero and oversize counts
  task automatic test_full_bucket();
    write_reg(RegHashMult, 32'hFFFF_FFFF);
    write_reg(RegHashAdd, 32'hFFFF_FFFF);
    write_reg(RegBucketCnt, 32'd1);
    for (int i = 0; i < 10; i++) send_key(32'h1000_0000 + i);
    send_key(32'h1000_0003);
    // zero and oversize counts fall back to one and the maximum
    write_reg(RegBucketCnt, 32'd0);
    send_key(32'h5555_AAAA);
    write_reg(RegBucketCnt, 32'h0000_07FF);
    send_key(32'hAAAA_5555);
    write_reg(2'd3, 32'hDEAD_BEEF);
    write_reg(RegHashMult, 32'd0);
    send_key(32'h1234_5678);
    send_key(32'h1234_5678);
  endtask

  task automatic test_random_keys(input int n_keys);
    logic [31:0] k;
    write_reg(RegHashMult, $urandom);
    write_reg(RegHashAdd, $urandom);
    case ($urandom_range(2))
      0: write_reg(RegBucketCnt, $urandom_range(16, 1));
      1: write_reg(RegBucketCnt, $urandom_range(1024, 1));
      default: write_reg(RegBucketCnt, 1024);
    endcase
    for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n_keys; i++) begin
      k = ($urandom_range(99) < 70) ? key_pool[$urandom_range(63)] : $urandom;
      send_key(k);
    end
  endtask

  // receiver stalls long enough for the input side to back up
  task automatic test_backpressure();
    snd_idle_pct = 0;
    hold_cycles  = 600;
    for (int i = 0; i < 40; i++) send_key($urandom);
  endtask

  initial begin
    mdl_mult = 32'd1;
    mdl_add = '0;
    mdl_bcount = 11'd1024;
    mdl_confl = 0;
    mdl_distinct = 0;
    mdl_maxfill = 0;
    for (int i = 0; i < NBUCK; i++) mdl_fill[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_keys();
    test_full_bucket();
    snd_idle_pct = 36; rcv_idle_pct = 52;
    test_random_keys(560);
    snd_idle_pct = 52; rcv_idle_pct = 36;
    test_random_keys(560);
    snd_idle_pct = 0; rcv_idle_pct = 0;
    test_random_keys(520);
    test_backpressure();
    drain();
    $display("covered %0d keys, %0d results: %0d duplicates, %0d dropped on full bucket",
             keys_sent, results_seen, dups_seen, overflows_seen);
    $display("hash settings swept incl. zero/oversize bucket counts and long output stall");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
